@@ hw/rtl/oofifo_pkg.sv @@
// Shared types, constants and a helper function for the overwrite-oldest ring FIFO.
`default_nettype none
package oofifo_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int IO_DATA_W   = 16;
  localparam int COUNT_W     = 4;
  localparam int REQ_W       = 2;
  localparam int OUT_TDATA_W = ((IO_DATA_W + COUNT_W + 2 + 7) / 8) * 8;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IO_DATA_W-1:0]  io_word_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [REQ_W-1:0]      req_t;

  localparam req_t REQ_QUERY   = 2'd0;
  localparam req_t REQ_ENQUEUE = 2'd1;
  localparam req_t REQ_DEQUEUE = 2'd2;
  localparam req_t REQ_CLEAR   = 2'd3;

  typedef struct packed {
    logic   valid;
    count_t count;
    logic   is_empty;
    logic   dropped;
    logic   use_empty;
    logic   fwd;
    word_t  fwd_data;
  } pend_t;

  function automatic ptr_t next_slot(input ptr_t i);
    return (i == ptr_t'(QUEUE_SLOTS - 1)) ? '0 : ptr_t'(i + 1'b1);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/oofifo_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module oofifo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/oofifo_ctrl.sv @@
// Request decoder and pointer/count logic that issues the RAM accesses.
`default_nettype none
module oofifo_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire oofifo_pkg::req_t    in_req,
  input  wire oofifo_pkg::word_t   in_word,
  input  wire logic                out_free,
  output logic                     in_ready,
  output logic                     ram_we,
  output oofifo_pkg::ptr_t         ram_waddr,
  output oofifo_pkg::word_t        ram_wdata,
  output logic                     ram_re,
  output oofifo_pkg::ptr_t         ram_raddr,
  output oofifo_pkg::pend_t        pend
);

  oofifo_pkg::ptr_t  front_r, front_nxt;
  oofifo_pkg::ptr_t  rear_r, rear_nxt;
  oofifo_pkg::ptr_t  cnt_r, cnt_nxt;
  oofifo_pkg::pend_t pend_r, pend_nxt;
  logic              accept;
  logic              full;
  logic              empty;
  logic              dropped;
  logic              deq_read;

  assign in_ready = !pend_r.valid && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (oofifo_pkg::next_slot(rear_r) == front_r);
  assign empty    = (front_r == rear_r);

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    cnt_nxt   = cnt_r;
    dropped   = 1'b0;
    deq_read  = 1'b0;
    ram_we    = 1'b0;
    unique case (in_req)
      oofifo_pkg::REQ_ENQUEUE: begin
        ram_we   = accept;
        rear_nxt = oofifo_pkg::next_slot(rear_r);
        if (full) begin
          front_nxt = oofifo_pkg::next_slot(front_r);
          dropped   = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      oofifo_pkg::REQ_DEQUEUE: begin
        if (!empty) begin
          front_nxt = oofifo_pkg::next_slot(front_r);
          cnt_nxt   = cnt_r - 1'b1;
          deq_read  = 1'b1;
        end
      end
      oofifo_pkg::REQ_CLEAR: begin
        front_nxt = '0;
        rear_nxt  = '0;
        cnt_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  assign ram_waddr = rear_nxt;
  assign ram_wdata = in_word;
  assign ram_re    = accept;
  assign ram_raddr = deq_read ? front_nxt : oofifo_pkg::next_slot(front_nxt);

  always_comb begin
    pend_nxt          = pend_r;
    pend_nxt.valid    = accept;
    if (accept) begin
      pend_nxt.count     = oofifo_pkg::count_t'(cnt_nxt);
      pend_nxt.is_empty  = (front_nxt == rear_nxt);
      pend_nxt.dropped   = dropped;
      pend_nxt.use_empty = !deq_read && (front_nxt == rear_nxt);
      pend_nxt.fwd       = ram_we && (ram_raddr == ram_waddr);
      pend_nxt.fwd_data  = in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      cnt_r   <= '0;
      pend_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (accept) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  assign pend = pend_r;

endmodule
`default_nettype wire

@@ hw/rtl/oofifo_outreg.sv @@
// Result output register with data selection and the empty-value register.
`default_nettype none
module oofifo_outreg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire oofifo_pkg::pend_t                   pend,
  input  wire oofifo_pkg::word_t                   ram_rdata,
  input  wire logic                                cfg_wr_en,
  input  wire oofifo_pkg::io_word_t                cfg_wr_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [oofifo_pkg::OUT_TDATA_W-1:0]       out_data,
  output logic                                     out_free
);

  oofifo_pkg::word_t                   empty_val_r;
  logic                                out_valid_r;
  logic [oofifo_pkg::OUT_TDATA_W-1:0]  out_data_r;
  oofifo_pkg::word_t                   word_sel;

  always_comb begin
    if (pend.use_empty) begin
      word_sel = empty_val_r;
    end else if (pend.fwd) begin
      word_sel = pend.fwd_data;
    end else begin
      word_sel = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_val_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        empty_val_r <= oofifo_pkg::word_t'(cfg_wr_data);
      end
      if (pend.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend.valid) begin
      out_data_r <= oofifo_pkg::OUT_TDATA_W'({pend.dropped, pend.is_empty, pend.count,
                                              oofifo_pkg::io_word_t'(word_sel)});
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

@@ hw/rtl/overwrite_oldest_ring_fifo_core.sv @@
// Top level of the ring FIFO that overwrites its oldest word when full.
//
//  Channel  Direction  Signals                          Contents
//  in       slave      in_tvalid/in_tready/in_tuser     request kind; tdata = data_in
//  out      master     out_tvalid/out_tready/out_tdata  data_out, count, is_empty, dropped
//  cfg      write-only cfg_wr_en/cfg_wr_data            empty value
//
// Each request issues its RAM access on the accepting edge, and the registered read data is
// merged into the output register in the following cycle.
// A new request is taken only when no result is pending and the output register is free.
// A stalled output holds its transfer and blocks further requests until it is taken.
// Reset clears the pointers, the count and the empty value; the RAM is not cleared.
`default_nettype none
module overwrite_oldest_ring_fifo_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [15:0]                         in_tdata,  // [15:0] data_in
  input  wire logic [1:0]                          in_tuser,  // [1:0] req_type
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [15:0] data_out, [19:16] count, [20] is_empty, [21] dropped_oldest, [23:22] zero
  output logic [oofifo_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [15:0]                         cfg_wr_data
);

  logic              out_free;
  logic              ram_we;
  logic              ram_re;
  oofifo_pkg::ptr_t  ram_waddr;
  oofifo_pkg::ptr_t  ram_raddr;
  oofifo_pkg::word_t ram_wdata;
  oofifo_pkg::word_t ram_rdata;
  oofifo_pkg::pend_t pend;

  oofifo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_req    (oofifo_pkg::req_t'(in_tuser)),
    .in_word   (oofifo_pkg::word_t'(in_tdata)),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .pend      (pend)
  );

  oofifo_ram #(
    .WIDTH (oofifo_pkg::DATA_WIDTH),
    .DEPTH (oofifo_pkg::QUEUE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  oofifo_outreg u_outreg (
    .clk         (clk),
    .rst_n       (rst_n),
    .pend        (pend),
    .ram_rdata   (ram_rdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (oofifo_pkg::io_word_t'(cfg_wr_data)),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_data    (out_tdata),
    .out_free    (out_free)
  );

endmodule
`default_nettype wire

@@ hw/rtl/oofifo_chk.sv @@
// Port-level checker for the ring FIFO core and its bind statement.
`default_nettype none
module oofifo_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [oofifo_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Output transfer withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("Output data changed while stalled.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("Accepted request produced no result.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second request taken while one is still in flight.");

  a_drop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> !out_tdata[20])
    else $error("Dropped-oldest result reports an empty FIFO.");

endmodule

bind overwrite_oldest_ring_fifo_core oofifo_chk u_chk (.*);
`default_nettype wire
